// File: sv/fss_pkg.sv
package fss_pkg;

   localparam int HIST_DEPTH        = 5;
   localparam int POSITION_BITS_DEF = 32;
   localparam int OFFSET_BITS       = 32;

   typedef enum logic [2:0] {
      SIG_PDF  = 3'd0,
      SIG_PNG  = 3'd1,
      SIG_ZIP  = 3'd2,
      SIG_RAR  = 3'd3,
      SIG_GZIP = 3'd4,
      SIG_7Z   = 3'd5,
      SIG_ELF  = 3'd6,
      SIG_JPEG = 3'd7
   } sig_type;

   // one history byte and whether it belongs to the current file
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } cell_type;

   // match report: code and distance back to the first byte of the pattern
   typedef struct packed {
      logic       hit;
      sig_type    sig;
      logic [2:0] back;
   } match_type;

   localparam logic [7:0] PDF_0 = 8'h25, PDF_1 = 8'h50, PDF_2 = 8'h44, PDF_3 = 8'h46;
   localparam logic [7:0] PNG_0 = 8'h50, PNG_1 = 8'h4E, PNG_2 = 8'h47;
   localparam logic [7:0] ZIP_0 = 8'h50, ZIP_1 = 8'h4B;
   localparam logic [7:0] ZIP_A_LO = 8'h04, ZIP_A_HI = 8'h08;
   localparam logic [7:0] ZIP_B_LO = 8'h05, ZIP_B_HI = 8'h08;
   localparam logic [7:0] RAR_0 = 8'h52, RAR_1 = 8'h61, RAR_2 = 8'h72;
   localparam logic [7:0] RAR_3 = 8'h21, RAR_4 = 8'h1A, RAR_5 = 8'h07;
   localparam logic [7:0] GZ_0 = 8'h1F, GZ_1 = 8'h8B, GZ_HI = 8'h08;
   localparam logic [7:0] SZ_0 = 8'h37, SZ_1 = 8'h7A, SZ_2 = 8'hBC;
   localparam logic [7:0] SZ_3 = 8'hAF, SZ_4 = 8'h27, SZ_5 = 8'h1C;
   localparam logic [7:0] ELF_0 = 8'h7F, ELF_1 = 8'h45, ELF_2 = 8'h4C, ELF_3 = 8'h46;
   localparam logic [7:0] JPG_0 = 8'hFF, JPG_1 = 8'hD8, JPG_2 = 8'hFF;
   localparam logic [7:0] JPG_3A = 8'hDB, JPG_3B = 8'hE0, JPG_3C = 8'hE1;

endpackage

// File: sv/file_signature_scanner_top.sv
// File signature scanner.
// Feed the file one byte per item on the req_ channel; set req_start_of_file
// on the first byte of each file. When a byte completes a known signature
// (pdf, png, zip, rar, gzip, 7z, elf, jpeg) one item leaves on the rsp_
// channel carrying the signature code and the offset of its first byte.
// Bytes that complete nothing produce no item.
// Throughput: one byte per cycle while req_ready is high, set by the row of
// five history cells that shift on every accepted byte and the comparators
// in front of them. Each result is registered before it leaves.
// Results pass through an output register backed by a one-entry skid buffer,
// so a stalled receiver costs nothing until both are full; req_ready then
// drops until the receiver takes an item.
// csr_wr_data bit 0 enables gzip reporting; write it only while idle.
// Reset (synchronous) empties the history, zeroes the byte position, clears
// the gzip enable and discards any pending result. The position saturates at
// its largest value; offsets carry its low 32 bits.
module file_signature_scanner_top
   import fss_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_signature,
   output logic [31:0] rsp_start_offset
);

   logic                     gzip_en_ff;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_cur, start_pos;
   logic [POSITION_BITS+OFFSET_BITS-1:0] start_wide;
   cell_type                 cells [HIST_DEPTH];
   cell_type                 hist  [HIST_DEPTH];
   cell_type                 head;
   match_type                match;
   logic                     accept, push, pop;
   logic                     out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [2:0]               out_sig_ff, out_sig_in, skid_sig_ff, skid_sig_in;
   logic [31:0]              out_off_ff, out_off_in, skid_off_ff, skid_off_in;
   logic [HIST_DEPTH-1:0]    valid_vec;

   assign accept = req_valid && req_ready;
   assign head   = '{valid: 1'b1, data: req_data_byte};

   // history row: cell 0 takes the new byte, the others take their neighbour
   for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         fss_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .clear    (1'b0),
            .prev     (head),
            .held     (cells[k])
         );
      end else begin : g_tail
         fss_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .clear    (req_start_of_file),
            .prev     (cells[k-1]),
            .held     (cells[k])
         );
      end
      // a new file sees an empty history
      assign hist[k]      = req_start_of_file ? '0 : cells[k];
      assign valid_vec[k] = cells[k].valid;
   end

   fss_match u_match (
      .cur     (req_data_byte),
      .hist    (hist),
      .gzip_en (gzip_en_ff),
      .match   (match)
   );

   // byte position, saturating
   always_comb begin
      pos_cur = req_start_of_file ? '0 : pos_ff;
      pos_in  = pos_ff;
      if (accept) begin
         pos_in = (pos_cur != '1) ? pos_cur + POSITION_BITS'(1) : pos_cur;
      end
   end

   assign start_pos  = pos_cur - POSITION_BITS'(match.back);
   assign start_wide = {{OFFSET_BITS{1'b0}}, start_pos};

   assign push = accept && match.hit;
   assign pop  = rsp_valid && rsp_ready;

   // output register with skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sig_in    = out_sig_ff;
      out_off_in    = out_off_ff;
      skid_valid_in = skid_valid_ff;
      skid_sig_in   = skid_sig_ff;
      skid_off_in   = skid_off_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_sig_in    = skid_sig_ff;
            out_off_in    = skid_off_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_sig_in   = match.sig;
            out_off_in   = start_wide[OFFSET_BITS-1:0];
         end else begin
            skid_valid_in = 1'b1;
            skid_sig_in   = match.sig;
            skid_off_in   = start_wide[OFFSET_BITS-1:0];
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gzip_en_ff    <= 1'b0;
         pos_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gzip_en_ff <= csr_wr_data;
         end
         pos_ff        <= pos_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sig_ff  <= out_sig_in;
      out_off_ff  <= out_off_in;
      skid_sig_ff <= skid_sig_in;
      skid_off_ff <= skid_off_in;
   end

   assign req_ready        = !skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_signature    = out_sig_ff;
   assign rsp_start_offset = out_off_ff;

   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      (valid_vec[HIST_DEPTH-1:1] & ~valid_vec[HIST_DEPTH-2:0]) == '0)
      else $error("history valid bits out of order");

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      accept |=> cells[0].valid)
      else $error("accepted byte not held in first cell");

   a_new_file_pos: assert property (@(posedge clock) disable iff (reset)
      (accept && req_start_of_file) |=> pos_ff == POSITION_BITS'(1))
      else $error("position not restarted on new file");

   a_overflow_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !pop) |=> skid_valid_ff)
      else $error("result lost while receiver stalled");

endmodule

// File: sv/fss_cell.sv
module fss_cell
   import fss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  logic     clear,
   input  cell_type prev,
   output cell_type held
);

   cell_type cell_ff, cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (shift_en) begin
         // drop the neighbour's byte when a new file starts
         cell_in = clear ? '0 : prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign held = cell_ff;

endmodule

// File: sv/fss_match.sv
module fss_match
   import fss_pkg::*;
(
   input  logic       [7:0] cur,
   input  cell_type         hist [HIST_DEPTH],
   input  logic             gzip_en,
   output match_type        match
);

   logic [7:0] h0, h1, h2, h3, h4;
   logic       have3, have4, have6;
   logic       m_pdf, m_png, m_zip, m_rar, m_gzip, m_7z, m_elf, m_jpeg;

   assign h0 = hist[0].data;
   assign h1 = hist[1].data;
   assign h2 = hist[2].data;
   assign h3 = hist[3].data;
   assign h4 = hist[4].data;

   // valid bits fill from the front, so the deepest needed cell decides
   assign have3 = hist[1].valid;
   assign have4 = hist[2].valid;
   assign have6 = hist[4].valid;

   assign m_pdf  = have4 && h2 == PDF_0 && h1 == PDF_1 && h0 == PDF_2 && cur == PDF_3;
   assign m_png  = have3 && h1 == PNG_0 && h0 == PNG_1 && cur == PNG_2;
   assign m_zip  = have4 && h2 == ZIP_0 && h1 == ZIP_1 &&
                   h0 >= ZIP_A_LO && h0 <= ZIP_A_HI && cur >= ZIP_B_LO && cur <= ZIP_B_HI;
   assign m_rar  = have6 && h4 == RAR_0 && h3 == RAR_1 && h2 == RAR_2 &&
                   h1 == RAR_3 && h0 == RAR_4 && cur == RAR_5;
   assign m_gzip = have4 && gzip_en && h2 == GZ_0 && h1 == GZ_1 &&
                   h0 <= GZ_HI && cur <= GZ_HI;
   assign m_7z   = have6 && h4 == SZ_0 && h3 == SZ_1 && h2 == SZ_2 &&
                   h1 == SZ_3 && h0 == SZ_4 && cur == SZ_5;
   assign m_elf  = have4 && h2 == ELF_0 && h1 == ELF_1 && h0 == ELF_2 && cur == ELF_3;
   assign m_jpeg = have4 && h2 == JPG_0 && h1 == JPG_1 && h0 == JPG_2 &&
                   (cur == JPG_3A || cur == JPG_3B || cur == JPG_3C);

   always_comb begin
      match = '{hit: 1'b0, sig: SIG_PDF, back: 3'd0};
      if (m_pdf) begin
         match = '{hit: 1'b1, sig: SIG_PDF, back: 3'd3};
      end else if (m_png) begin
         match = '{hit: 1'b1, sig: SIG_PNG, back: 3'd2};
      end else if (m_zip) begin
         match = '{hit: 1'b1, sig: SIG_ZIP, back: 3'd3};
      end else if (m_rar) begin
         match = '{hit: 1'b1, sig: SIG_RAR, back: 3'd5};
      end else if (m_gzip) begin
         match = '{hit: 1'b1, sig: SIG_GZIP, back: 3'd3};
      end else if (m_7z) begin
         match = '{hit: 1'b1, sig: SIG_7Z, back: 3'd5};
      end else if (m_elf) begin
         match = '{hit: 1'b1, sig: SIG_ELF, back: 3'd3};
      end else if (m_jpeg) begin
         match = '{hit: 1'b1, sig: SIG_JPEG, back: 3'd3};
      end
   end

endmodule
